// File: rtl/format_spec_parser_unit_macros.svh
// ---------------------------------------------------------------------------
// Format spec parser assertion macros
// Implication checks on the clock, with an empty body for synthesis.
// ---------------------------------------------------------------------------
`ifndef FORMAT_SPEC_PARSER_UNIT_MACROS_SVH
`define FORMAT_SPEC_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define FSP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("format spec parser: same-cycle check failed");

`define FSP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("format spec parser: next-cycle check failed");

`else

`define FSP_ASSERT_IMP(label, clk, rst, ante, cons)

`define FSP_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/fsp_pkg.sv
// ---------------------------------------------------------------------------
// Format spec parser package
// Character codes, parse state, and the per-byte update functions.
// ---------------------------------------------------------------------------
package fsp_pkg;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] SAT_MAX  = 8'd255;

   typedef enum logic [10:0] {
      PH_START = 11'b000_0000_0001,
      PH_COLON = 11'b000_0000_0010,
      PH_HELD  = 11'b000_0000_0100,
      PH_SIGN  = 11'b000_0000_1000,
      PH_HASH  = 11'b000_0001_0000,
      PH_ZERO  = 11'b000_0010_0000,
      PH_WIDTH = 11'b000_0100_0000,
      PH_POINT = 11'b000_1000_0000,
      PH_PREC  = 11'b001_0000_0000,
      PH_TYPE  = 11'b010_0000_0000,
      PH_DONE  = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] held_first;
      logic [7:0] fill;
      logic [7:0] align;
      logic [7:0] sign;
      logic       prefix;
      logic [7:0] width;
      logic       point;
      logic [7:0] precision;
      logic [7:0] type_char;
   } state_type;

   localparam state_type ST_RESET = '{
      phase:      PH_START,
      held_first: 8'd0,
      fill:       8'd0,
      align:      8'd0,
      sign:       8'd0,
      prefix:     1'b0,
      width:      8'd0,
      point:      1'b0,
      precision:  8'd0,
      type_char:  8'd0
   };

   function automatic logic is_align(logic [7:0] b);
      return (b == CH_LT) || (b == CH_GT) || (b == CH_EQ) || (b == CH_CARET);
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   // acc * 10 + digit, clamped
   function automatic logic [7:0] sat_acc(logic [7:0] acc, logic [7:0] b);
      logic [11:0] n;
      logic [7:0]  d;
      d = b - CH_ZERO;
      n = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {8'd0, d[3:0]};
      return (n < {4'd0, SAT_MAX}) ? n[7:0] : SAT_MAX;
   endfunction

   // one byte once fill and align are settled; phases fall through
   function automatic state_type take(state_type s, logic [7:0] b);
      state_type r;
      logic      done;
      r    = s;
      done = 1'b0;
      if (r.phase == PH_SIGN) begin
         r.phase = PH_HASH;
         if ((b == CH_PLUS) || (b == CH_MINUS) || (b == CH_SPACE)) begin
            r.sign = b;
            done   = 1'b1;
         end
      end
      if (!done && (r.phase == PH_HASH)) begin
         r.phase = PH_ZERO;
         if (b == CH_HASH) begin
            r.prefix = 1'b1;
            done     = 1'b1;
         end
      end
      if (!done && (r.phase == PH_ZERO)) begin
         r.phase = PH_WIDTH;
         if ((r.fill == 8'd0) && (b == CH_ZERO)) begin
            r.fill = b;
            done   = 1'b1;
         end
      end
      if (!done && (r.phase == PH_WIDTH)) begin
         if (is_digit(b)) begin
            r.width = sat_acc(r.width, b);
            done    = 1'b1;
         end else begin
            r.phase = PH_POINT;
         end
      end
      if (!done && (r.phase == PH_POINT)) begin
         if (b == CH_DOT) begin
            r.point = 1'b1;
            r.phase = PH_PREC;
            done    = 1'b1;
         end else begin
            r.phase = PH_TYPE;
         end
      end
      if (!done && (r.phase == PH_PREC)) begin
         if (is_digit(b)) begin
            r.precision = sat_acc(r.precision, b);
            done        = 1'b1;
         end else begin
            r.phase = PH_TYPE;
         end
      end
      if (!done && (r.phase == PH_TYPE)) begin
         r.type_char = b;
         r.phase     = PH_DONE;
      end
      return r;
   endfunction

   function automatic state_type accept_byte(state_type s, logic [7:0] b);
      state_type r;
      r = s;
      unique case (s.phase) inside
         PH_START: begin
            if (b == CH_COLON) begin
               r.phase = PH_COLON;
            end else begin
               r.held_first = b;
               r.phase      = PH_HELD;
            end
         end
         PH_COLON: begin
            r.held_first = b;
            r.phase      = PH_HELD;
         end
         PH_HELD: begin
            r.phase = PH_SIGN;
            if (is_align(b)) begin
               r.fill  = s.held_first;
               r.align = b;
            end else if (is_align(s.held_first)) begin
               r.align = s.held_first;
               r       = take(r, b);
            end else begin
               r = take(r, s.held_first);
               r = take(r, b);
            end
         end
         PH_SIGN, PH_HASH, PH_ZERO, PH_WIDTH, PH_POINT, PH_PREC, PH_TYPE: begin
            r = take(s, b);
         end
         default: begin
            r = s;
         end
      endcase
      return r;
   endfunction

endpackage

// File: rtl/format_spec_parser_unit.sv
// ---------------------------------------------------------------------------
// Format spec parser unit
// Parses a [[fill]align][sign][#][0][width][.precision][type] string, one
// byte per word, and gives one result word on the word marked last.
// ---------------------------------------------------------------------------
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  ch, has_char, last
//   rsp_      out         rsp_valid / rsp_stall  valid_res .. type_char
//
// One word per cycle while req_stall is low. A word goes through the input
// register, then the parse logic, and a last word's result is captured in
// the result register. Synchronous reset returns the parse state to start of string.
// A stalled result only holds back a following last word; other words keep
// flowing into the parse state.
// ---------------------------------------------------------------------------
`include "format_spec_parser_unit_macros.svh"

module format_spec_parser_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_has_char,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_valid_res,
   output logic [7:0] rsp_fill,
   output logic [7:0] rsp_align,
   output logic [7:0] rsp_sign,
   output logic [7:0] rsp_prefix,
   output logic [7:0] rsp_width,
   output logic [7:0] rsp_point,
   output logic [7:0] rsp_precision,
   output logic [7:0] rsp_type_char
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_ch_ff;
   logic               in_has_char_ff;
   logic               in_last_ff;
   logic               req_accept;
   logic               advance;
   logic               emit;

   fsp_pkg::state_type st_ff, st_in;
   fsp_pkg::state_type st_byte;
   fsp_pkg::state_type st_fin;
   logic               fin_valid;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_valid_res_ff;
   logic [7:0]         rsp_fill_ff;
   logic [7:0]         rsp_align_ff;
   logic [7:0]         rsp_sign_ff;
   logic [7:0]         rsp_prefix_ff;
   logic [7:0]         rsp_width_ff;
   logic [7:0]         rsp_point_ff;
   logic [7:0]         rsp_precision_ff;
   logic [7:0]         rsp_type_char_ff;

   // advance unless a last word would overrun a stalled result
   assign advance    = in_valid_ff && !(in_last_ff && rsp_valid_ff && rsp_stall);
   assign emit       = advance && in_last_ff;
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         in_ch_ff       <= req_ch;
         in_has_char_ff <= req_has_char;
         in_last_ff     <= req_last;
      end
   end

   always_comb begin
      st_byte = in_has_char_ff ? fsp_pkg::accept_byte(st_ff, in_ch_ff) : st_ff;
      fin_valid = (st_byte.phase != fsp_pkg::PH_START) &&
                  (st_byte.phase != fsp_pkg::PH_COLON);
      st_fin = st_byte;
      // a single held byte at the end
      if (st_byte.phase == fsp_pkg::PH_HELD) begin
         st_fin.phase = fsp_pkg::PH_SIGN;
         if (fsp_pkg::is_align(st_byte.held_first)) begin
            st_fin.align = st_byte.held_first;
         end else begin
            st_fin = fsp_pkg::take(st_fin, st_byte.held_first);
         end
      end
      st_in = in_last_ff ? fsp_pkg::ST_RESET : st_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= fsp_pkg::ST_RESET;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_valid_res_ff <= fin_valid;
         rsp_fill_ff      <= st_fin.fill;
         rsp_align_ff     <= st_fin.align;
         rsp_sign_ff      <= st_fin.sign;
         rsp_prefix_ff    <= st_fin.prefix ? fsp_pkg::CH_HASH : 8'd0;
         rsp_width_ff     <= st_fin.width;
         rsp_point_ff     <= st_fin.point ? fsp_pkg::CH_DOT : 8'd0;
         rsp_precision_ff <= st_fin.precision;
         rsp_type_char_ff <= st_fin.type_char;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_valid_res_ff;
   assign rsp_fill      = rsp_fill_ff;
   assign rsp_align     = rsp_align_ff;
   assign rsp_sign      = rsp_sign_ff;
   assign rsp_prefix    = rsp_prefix_ff;
   assign rsp_width     = rsp_width_ff;
   assign rsp_point     = rsp_point_ff;
   assign rsp_precision = rsp_precision_ff;
   assign rsp_type_char = rsp_type_char_ff;

   `FSP_ASSERT_NXT(a_restart_after_result, clock, reset, emit, st_ff.phase == fsp_pkg::PH_START)
   `FSP_ASSERT_IMP(a_empty_is_zero, clock, reset, rsp_valid_ff && !rsp_valid_res_ff, rsp_fill_ff == 8'd0 && rsp_width_ff == 8'd0 && rsp_type_char_ff == 8'd0)
   `FSP_ASSERT_IMP(a_start_is_clean, clock, reset, st_ff.phase == fsp_pkg::PH_START, st_ff.width == 8'd0 && st_ff.fill == 8'd0 && !st_ff.point)
   `FSP_ASSERT_IMP(a_hold_last_word, clock, reset, in_valid_ff && in_last_ff && rsp_valid_ff && rsp_stall, req_stall && !advance)

endmodule
